/* rtl/tcp_flow_out_of_sequence_counter_defines.svh */
// assertion macros for the flow counter file
`ifndef TCP_FLOW_OUT_OF_SEQUENCE_COUNTER_DEFINES_SVH
`define TCP_FLOW_OUT_OF_SEQUENCE_COUNTER_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define TFOSC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TFOSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tfosc_pkg.sv */
package tfosc_pkg;

   // table geometry
   localparam int FLOW_ENTRIES = 1024;

   // field widths
   localparam int IP_W    = 32;
   localparam int PORT_W  = 16;
   localparam int PROTO_W = 8;
   localparam int SEQ_W   = 32;
   localparam int LEN_W   = 16;
   localparam int CNT_W   = 32;

   // entry layout: valid, addresses, ports and protocol, expected sequence, count
   localparam int ADDR_KEY_W = 2 * IP_W;
   localparam int PPP_KEY_W  = 2 * PORT_W + PROTO_W;
   localparam int KEY_W      = ADDR_KEY_W + PPP_KEY_W;
   localparam int ENTRY_W    = 1 + KEY_W + SEQ_W + CNT_W;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_PROBE = 3'b100
   } state_type;

endpackage

/* rtl/tfosc_ram.sv */
module tfosc_ram #(
   parameter int W = 8,
   parameter int D = 16,
   localparam int AW = (D > 1) ? $clog2(D) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0] mem [D];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/tcp_flow_out_of_sequence_counter.sv */
// channel   | ports                              | transfer when
// ----------+------------------------------------+---------------------------
// request   | start, busy, req_* fields          | start high and busy low
// response  | rsp_strobe, rsp_* fields           | rsp_strobe high, one cycle
//
// The flow table is one single-port-write RAM probed from a hash of the key.
// A packet is probed first at its hash address, then at each following entry
// on a hash collision (linear probing); a miss on a full table scans all entries.
// After reset a clearing pass zeroes every table entry, busy high.
// When the first probe settles a packet, its response is registered after the
// table read; the receiver cannot stall, a new request is taken during the strobe.
`include "tcp_flow_out_of_sequence_counter_defines.svh"

module tcp_flow_out_of_sequence_counter #(
   parameter int FLOW_ENTRIES = tfosc_pkg::FLOW_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tfosc_pkg::IP_W-1:0]       req_src_ip,
   input  logic [tfosc_pkg::IP_W-1:0]       req_dst_ip,
   input  logic [tfosc_pkg::PORT_W-1:0]     req_src_port,
   input  logic [tfosc_pkg::PORT_W-1:0]     req_dst_port,
   input  logic [tfosc_pkg::PROTO_W-1:0]    req_protocol,
   input  logic [tfosc_pkg::SEQ_W-1:0]      req_seq_number,
   input  logic [tfosc_pkg::LEN_W-1:0]      req_payload_length,
   input  logic                             req_syn_flag,
   input  logic                             req_fin_flag,
   output logic                             rsp_strobe,
   output logic [tfosc_pkg::CNT_W-1:0]      rsp_out_of_sequence_count,
   output logic                             rsp_new_flow,
   output logic                             rsp_table_full
);

   localparam int AW      = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CW      = $clog2(FLOW_ENTRIES + 1);
   localparam int KEY_W   = tfosc_pkg::KEY_W;
   localparam int SEQ_W   = tfosc_pkg::SEQ_W;
   localparam int CNT_W   = tfosc_pkg::CNT_W;
   localparam int ENTRY_W = tfosc_pkg::ENTRY_W;

   tfosc_pkg::state_type state_ff, state_in;

   logic [KEY_W-1:0]               key_ff, key_in;
   logic [SEQ_W-1:0]               seq_ff, seq_in;
   logic [SEQ_W-1:0]               step_ff, step_in;
   logic [AW-1:0]                  probe_addr_ff, probe_addr_in;
   logic [AW-1:0]                  probes_ff, probes_in;
   logic [CW-1:0]                  fill_ff, fill_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [CNT_W-1:0]               rsp_cnt_ff, rsp_cnt_in;
   logic                           rsp_new_ff, rsp_new_in;
   logic                           rsp_full_ff, rsp_full_in;

   logic [KEY_W-1:0]               req_key;
   logic [AW-1:0]                  hash_fold;
   logic [AW-1:0]                  hash_addr;
   logic [AW-1:0]                  next_addr;
   logic                           accept;

   logic                           wr_en, rd_en;
   logic [AW-1:0]                  wr_addr, rd_addr;
   logic [ENTRY_W-1:0]             wr_data, rd_data;

   logic                           ent_valid;
   logic [KEY_W-1:0]               ent_key;
   logic [SEQ_W-1:0]               ent_exp;
   logic [CNT_W-1:0]               ent_cnt;
   logic                           hit;
   logic [SEQ_W-1:0]               base_exp;
   logic [CNT_W-1:0]               base_cnt;
   logic [SEQ_W-1:0]               new_exp;
   logic [CNT_W-1:0]               new_cnt;

   assign accept  = start && (state_ff == tfosc_pkg::ST_IDLE);
   assign busy    = (state_ff != tfosc_pkg::ST_IDLE);
   assign req_key = {req_src_ip, req_dst_ip, req_src_port, req_dst_port, req_protocol};

   // xor-fold the key down to an index, then bring it below the table depth
   always_comb begin
      hash_fold = '0;
      for (int i = 0; i < KEY_W; i++) begin
         hash_fold[i % AW] = hash_fold[i % AW] ^ req_key[i];
      end
      if ({1'b0, hash_fold} >= (AW+1)'(FLOW_ENTRIES)) begin
         hash_addr = AW'({1'b0, hash_fold} - (AW+1)'(FLOW_ENTRIES));
      end else begin
         hash_addr = hash_fold;
      end
   end

   // linear probe step with wrap
   assign next_addr = (probe_addr_ff == AW'(FLOW_ENTRIES - 1)) ? '0 : probe_addr_ff + 1'b1;

   // unpack the entry read for the current probe
   assign ent_valid = rd_data[ENTRY_W-1];
   assign ent_key   = rd_data[ENTRY_W-2 -: KEY_W];
   assign ent_exp   = rd_data[SEQ_W+CNT_W-1 -: SEQ_W];
   assign ent_cnt   = rd_data[CNT_W-1:0];
   assign hit       = ent_valid && (ent_key == key_ff);

   // update of the flow; a fresh flow starts at the packet sequence
   always_comb begin
      base_exp = hit ? ent_exp : seq_ff;
      base_cnt = hit ? ent_cnt : '0;
      if ((base_exp != seq_ff) && (base_cnt != '1)) begin
         new_cnt = base_cnt + 1'b1;
      end else begin
         new_cnt = base_cnt;
      end
      new_exp = base_exp + step_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      seq_in        = seq_ff;
      step_in       = step_ff;
      probe_addr_in = probe_addr_ff;
      probes_in     = probes_ff;
      fill_in       = fill_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_full_in   = rsp_full_ff;
      wr_en         = 1'b0;
      wr_addr       = probe_addr_ff;
      wr_data       = {1'b1, key_ff, new_exp, new_cnt};
      rd_en         = 1'b0;
      rd_addr       = hash_addr;
      case (state_ff)
         tfosc_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(FLOW_ENTRIES - 1)) begin
               state_in = tfosc_pkg::ST_IDLE;
            end
         end
         tfosc_pkg::ST_IDLE: begin
            if (accept) begin
               rd_en         = 1'b1;
               key_in        = req_key;
               seq_in        = req_seq_number;
               step_in       = (req_syn_flag || req_fin_flag) ? SEQ_W'(1)
                                                              : SEQ_W'(req_payload_length);
               probe_addr_in = hash_addr;
               probes_in     = '0;
               state_in      = tfosc_pkg::ST_PROBE;
            end
         end
         tfosc_pkg::ST_PROBE: begin
            if (hit || !ent_valid) begin
               // known flow or free slot: write back and respond
               wr_en         = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_cnt_in    = new_cnt;
               rsp_new_in    = !hit;
               rsp_full_in   = 1'b0;
               if (!hit) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = tfosc_pkg::ST_IDLE;
            end else if (probes_ff == AW'(FLOW_ENTRIES - 1)) begin
               // every entry taken by another flow
               rsp_strobe_in = 1'b1;
               rsp_cnt_in    = '0;
               rsp_new_in    = 1'b0;
               rsp_full_in   = 1'b1;
               state_in      = tfosc_pkg::ST_IDLE;
            end else begin
               rd_en         = 1'b1;
               rd_addr       = next_addr;
               probe_addr_in = next_addr;
               probes_in     = probes_ff + 1'b1;
            end
         end
         default: begin
            state_in = tfosc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tfosc_pkg::ST_CLEAR;
         clr_ff        <= '0;
         fill_ff       <= '0;
         probes_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         fill_ff       <= fill_in;
         probes_ff     <= probes_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      seq_ff        <= seq_in;
      step_ff       <= step_in;
      probe_addr_ff <= probe_addr_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_full_ff   <= rsp_full_in;
   end

   // flow table
   tfosc_ram #(
      .W (ENTRY_W),
      .D (FLOW_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe                = rsp_strobe_ff;
   assign rsp_out_of_sequence_count = rsp_cnt_ff;
   assign rsp_new_flow              = rsp_new_ff;
   assign rsp_table_full            = rsp_full_ff;

   // checks
   `TFOSC_ASSERT_NEXT(a_strobe_gap, rsp_strobe_ff, !rsp_strobe_ff, "back-to-back response strobes")
   `TFOSC_ASSERT_NOW(a_full_result, rsp_strobe_ff && rsp_full_ff, rsp_cnt_ff == '0 && !rsp_new_ff, "full result carries data")
   `TFOSC_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= CW'(FLOW_ENTRIES), "fill count past depth")
   `TFOSC_ASSERT_NOW(a_insert_room, wr_en && (state_ff == tfosc_pkg::ST_PROBE) && !hit, fill_ff < CW'(FLOW_ENTRIES), "insert into full table")

endmodule
